[hw/rtl/alpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package alpd_pkg;

   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 20;
   localparam int LINE_LENGTH_BITS = 13;
   localparam int DELAY_BITS       = 20;
   localparam int GAIN_BITS        = 16;
   localparam int FRAC_BITS        = 8;

   localparam logic [CSR_INDEX_BITS-1:0] REG_LINE_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DELAY_Q8    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN        = 2'd2;

   localparam logic [LINE_LENGTH_BITS-1:0] LINE_LENGTH_RESET = 13'd4096;
   localparam logic [DELAY_BITS-1:0]       DELAY_Q8_RESET    = 20'd256;
   localparam logic [GAIN_BITS-1:0]        GAIN_RESET        = 16'd16384;

   typedef struct packed {
      logic take;
      logic feed;
      logic mul2;
      logic fin;
   } calc_ctl_type;

endpackage

`default_nettype wire

[hw/rtl/alpd_ring.sv]
`timescale 1ns / 1ps
`default_nettype none

module alpd_ring #(
   parameter int DEPTH       = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  wire                           clock,
   input  wire                           wr_en,
   input  wire  [$clog2(DEPTH)-1:0]      wr_addr,
   input  wire  [SAMPLE_BITS-1:0]        wr_data,
   input  wire                           rd_en,
   input  wire  [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [SAMPLE_BITS-1:0]        rd_data
);

   logic [SAMPLE_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/alpd_calc.sv]
`timescale 1ns / 1ps
`default_nettype none

module alpd_calc #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  alpd_pkg::calc_ctl_type           ctl,
   input  wire  [alpd_pkg::GAIN_BITS-1:0]   gain,
   input  wire  [SAMPLE_BITS-1:0]           sample_in,
   input  wire  [alpd_pkg::FRAC_BITS-1:0]   frac,
   input  wire  [SAMPLE_BITS-1:0]           rd_data,
   output logic [SAMPLE_BITS-1:0]           v,
   output logic [SAMPLE_BITS-1:0]           y
);

   localparam int SB = SAMPLE_BITS;
   localparam int PB = alpd_pkg::GAIN_BITS + SB;
   localparam int WB = SB + 3;
   localparam int IB = SB + 10;

   logic signed [SB-1:0] x_ff;
   logic signed [PB-1:0] p1_ff;
   logic signed [SB-1:0] v_ff;
   logic signed [PB-1:0] p2_ff;
   logic signed [SB-1:0] a_ff;
   logic signed [SB-1:0] d_ff;
   logic signed [SB-1:0] d_in;

   function automatic logic [SB+1:0] rnd15(input logic [PB-1:0] p);
      logic [PB:0] e;
      e = {p[PB-1], p} + (PB+1)'(16384);
      return e[PB:15];
   endfunction

   function automatic logic [SB-1:0] sat(input logic [WB-1:0] w);
      logic fits;
      fits = (w[WB-1:SB-1] == '0) || (w[WB-1:SB-1] == '1);
      if (fits) begin
         return w[SB-1:0];
      end else if (w[WB-1]) begin
         return {1'b1, {(SB-1){1'b0}}};
      end else begin
         return {1'b0, {(SB-1){1'b1}}};
      end
   endfunction

   logic [SB+1:0]        r1;
   logic [SB+1:0]        r2;
   logic [WB-1:0]        v_w;
   logic [WB-1:0]        y_w;
   logic signed [SB:0]   dba;
   logic signed [IB-1:0] prod;
   logic signed [IB-1:0] sum;

   always_comb begin
      r1  = rnd15(p1_ff);
      v_w = {{3{x_ff[SB-1]}}, x_ff} - {r1[SB+1], r1};
      v   = sat(v_w);
      r2  = rnd15(p2_ff);
      y_w = {r2[SB+1], r2} + {{3{d_ff[SB-1]}}, d_ff};
      y   = sat(y_w);
      dba  = $signed({rd_data[SB-1], rd_data}) - $signed({a_ff[SB-1], a_ff});
      prod = $signed({{(IB-SB-1){dba[SB]}}, dba}) * $signed({1'b0, frac});
      sum  = $signed({{2{a_ff[SB-1]}}, a_ff, 8'h00}) + prod + IB'(128);
      d_in = sum[SB+7:8];
   end

   always_ff @(posedge clock) begin
      p1_ff <= $signed(gain) * d_ff;
      if (ctl.take) begin
         x_ff <= sample_in;
      end
      if (ctl.feed) begin
         v_ff <= v;
      end
      if (ctl.mul2) begin
         p2_ff <= $signed(gain) * v_ff;
         a_ff  <= rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff <= '0;
      end else if (ctl.fin) begin
         d_ff <= d_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/allpass_fractional_delay.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                                  direction
// req       req_valid req_ready req_sample_in      in
// rsp       rsp_valid rsp_ready rsp_sample_out     out
// csr       csr_valid csr_ready csr_index csr_data in
//
// each item steps through accept, feed and write with first tap read,
// second tap read and output gain multiply, output and interpolation.
// the ring memory's single read port puts the tap reads in separate steps.
// after reset the ring is cleared with req_ready low.
// a write pointer beyond a shortened line is reduced mod len in S_MOD.
// a result waiting in the output register stalls only the output step.

module allpass_fractional_delay #(
   parameter int DEPTH       = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  [SAMPLE_BITS-1:0]                req_sample_in,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic [SAMPLE_BITS-1:0]                rsp_sample_out,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [alpd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire  [alpd_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);
   localparam int CW = (LW > alpd_pkg::LINE_LENGTH_BITS) ? LW : alpd_pkg::LINE_LENGTH_BITS;
   localparam int DW = (LW + 8 > alpd_pkg::DELAY_BITS) ? LW + 8 : alpd_pkg::DELAY_BITS;
   localparam int PW = DW + 1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_FEED,
      S_MUL2,
      S_OUT
   } state_type;

   state_type state_ff;
   logic [AW-1:0] wp_ff;
   logic [AW-1:0] cnt_ff;
   logic [LW-1:0] r_ff;
   logic [AW-1:0] q_ff;
   logic [AW-1:0] nxt_ff;
   logic [alpd_pkg::FRAC_BITS-1:0] frac_ff;
   logic rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_data_ff;

   logic [alpd_pkg::LINE_LENGTH_BITS-1:0] line_length_ff;
   logic [alpd_pkg::DELAY_BITS-1:0]       delay_q8_ff;
   logic [alpd_pkg::GAIN_BITS-1:0]        gain_ff;

   logic [CW-1:0] llx;
   logic [CW-1:0] len_c;
   logic [LW-1:0] len;
   logic [DW-1:0] dq_hi;
   logic [DW-1:0] dqx;
   logic [DW-1:0] dq;
   logic [PW-1:0] diffw;
   logic [PW-1:0] pos_w;
   logic [AW-1:0] idx;
   logic [LW-1:0] idx_p1;
   logic [AW-1:0] nxt;
   logic [LW-1:0] wp_p1;
   logic          wp_big;
   logic [LW:0]   sh;
   logic [LW:0]   rn;
   logic          req_fire;
   logic          csr_fire;
   logic          out_go;

   alpd_pkg::calc_ctl_type ctl;
   logic [SAMPLE_BITS-1:0] v;
   logic [SAMPLE_BITS-1:0] y;
   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [SAMPLE_BITS-1:0] mem_wr_data;
   logic                   mem_rd_en;
   logic [AW-1:0]          mem_rd_addr;
   logic [SAMPLE_BITS-1:0] mem_rd_data;

   // effective length, delay and tap positions
   always_comb begin
      llx = CW'(line_length_ff);
      if (llx < CW'(2)) begin
         len_c = CW'(2);
      end else if (llx > CW'(DEPTH)) begin
         len_c = CW'(DEPTH);
      end else begin
         len_c = llx;
      end
      len   = len_c[LW-1:0];
      dq_hi = DW'({len - LW'(1), 8'h00});
      dqx   = DW'(delay_q8_ff);
      if (dqx < DW'(256)) begin
         dq = DW'(256);
      end else if (dqx > dq_hi) begin
         dq = dq_hi;
      end else begin
         dq = dqx;
      end
      diffw = PW'({wp_ff, 8'h00}) - PW'(dq);
      pos_w = diffw[PW-1] ? diffw + PW'({len, 8'h00}) : diffw;
      idx   = pos_w[AW+7:8];
      idx_p1 = LW'(idx) + LW'(1);
      nxt   = (idx_p1 == len) ? '0 : idx_p1[AW-1:0];
      wp_p1 = LW'(wp_ff) + LW'(1);
      wp_big = LW'(wp_ff) >= len;
      sh = {r_ff, q_ff[AW-1]};
      rn = (sh >= {1'b0, len}) ? sh - {1'b0, len} : sh;
   end

   assign req_ready = (state_ff == S_IDLE) && !csr_valid && !wp_big;
   assign csr_ready = (state_ff == S_IDLE) || (state_ff == S_CLEAR) || (state_ff == S_MOD);
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign out_go    = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   always_comb begin
      ctl.take = req_fire;
      ctl.feed = (state_ff == S_FEED);
      ctl.mul2 = (state_ff == S_MUL2);
      ctl.fin  = out_go;
      mem_wr_en   = (state_ff == S_CLEAR) || (state_ff == S_FEED);
      mem_wr_addr = (state_ff == S_CLEAR) ? cnt_ff : wp_ff;
      mem_wr_data = (state_ff == S_CLEAR) ? '0 : v;
      mem_rd_en   = (state_ff == S_FEED) || (state_ff == S_MUL2);
      mem_rd_addr = (state_ff == S_FEED) ? idx : nxt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= alpd_pkg::LINE_LENGTH_RESET;
         delay_q8_ff    <= alpd_pkg::DELAY_Q8_RESET;
         gain_ff        <= alpd_pkg::GAIN_RESET;
      end else if (csr_fire) begin
         unique case (csr_index)
            alpd_pkg::REG_LINE_LENGTH: begin
               line_length_ff <= csr_data[alpd_pkg::LINE_LENGTH_BITS-1:0];
            end
            alpd_pkg::REG_DELAY_Q8: begin
               delay_q8_ff <= csr_data[alpd_pkg::DELAY_BITS-1:0];
            end
            alpd_pkg::REG_GAIN: begin
               gain_ff <= csr_data[alpd_pkg::GAIN_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !out_go) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + AW'(1);
               if (cnt_ff == AW'(DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (csr_fire) begin
                  state_ff <= S_IDLE;
               end else if (wp_big) begin
                  r_ff     <= '0;
                  q_ff     <= wp_ff;
                  cnt_ff   <= '0;
                  state_ff <= S_MOD;
               end else if (req_fire) begin
                  state_ff <= S_FEED;
               end
            end
            S_MOD: begin
               r_ff   <= rn[LW-1:0];
               q_ff   <= q_ff << 1;
               cnt_ff <= cnt_ff + AW'(1);
               if (csr_fire) begin
                  state_ff <= S_IDLE;
               end else if (cnt_ff == AW'(AW - 1)) begin
                  wp_ff    <= rn[AW-1:0];
                  state_ff <= S_IDLE;
               end
            end
            S_FEED: begin
               nxt_ff   <= nxt;
               frac_ff  <= pos_w[7:0];
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= y;
                  wp_ff        <= (wp_p1 == len) ? '0 : wp_p1[AW-1:0];
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   alpd_ring #(
      .DEPTH       (DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   alpd_calc #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_calc (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .gain      (gain_ff),
      .sample_in (req_sample_in),
      .frac      (frac_ff),
      .rd_data   (mem_rd_data),
      .v         (v),
      .y         (y)
   );

endmodule

`default_nettype wire

[hw/rtl/alpd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module alpd_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  req_valid,
   input wire                                  req_ready,
   input wire                                  rsp_valid,
   input wire                                  rsp_ready,
   input wire  [SAMPLE_BITS-1:0]               rsp_sample_out,
   input wire                                  csr_ready
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
      else $error("result dropped or changed while stalled");

   // one item at a time, req_ready low through feed, multiply and output
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("item accepted while another is in work");

   // no register write during the feed and multiply steps of an item
   a_csr_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !csr_ready ##1 !csr_ready)
      else $error("configuration taken during an item");

   // clearing pass follows reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("item or result right after reset");

endmodule

bind allpass_fractional_delay alpd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_alpd_checker (.*);

`default_nettype wire
